/* rtl/aes_pkg.sv */
// aes_pkg: shared types, constants and byte functions for the aes128 cbc engine
// depends on nothing; used by the round unit, key unit and top level
package aes_pkg;

    localparam int ROUND_COUNT = 10;

    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_KEY_HI  = 3'd1;
    localparam logic [2:0] REG_KEY_LO  = 3'd2;
    localparam logic [2:0] REG_IV_HI   = 3'd3;
    localparam logic [2:0] REG_IV_LO   = 3'd4;

    localparam logic [7:0] POLY_LOW  = 8'h1b;
    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef struct packed {
        logic       start;
        logic       decrypt;
        logic       final_round;
        logic       first_round;
    } round_ctl_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? POLY_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        gmul = (b[0] ? a : 8'h00) ^ (b[1] ? x2 : 8'h00) ^
               (b[2] ? x4 : 8'h00) ^ (b[3] ? x8 : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p, t;
        p = 8'h00;
        t = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ t;
            t = xtime(t);
        end
        gf_mul8 = p;
    endfunction

    // inverse via a^254 as a table-like constant function
    function automatic logic [7:0] gf_inv(input logic [7:0] a);
        logic [7:0] r, p;
        r = 8'h01;
        p = a;
        for (int i = 0; i < 8; i++) begin
            if (i != 0) r = gf_mul8(r, p);
            p = gf_mul8(p, p);
        end
        gf_inv = r;
    endfunction

    function automatic logic [7:0] rotl(input logic [7:0] x, input int n);
        rotl = (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] b;
        b = gf_inv(x);
        sbox_calc = b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox_calc(input logic [7:0] s);
        inv_sbox_calc = gf_inv(rotl(s, 1) ^ rotl(s, 3) ^ rotl(s, 6) ^ 8'h05);
    endfunction

    typedef logic [7:0] sbox_tab_t [256];

    function automatic sbox_tab_t make_sbox(input logic inv);
        sbox_tab_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = inv ? inv_sbox_calc(8'(i)) : sbox_calc(8'(i));
        end
        return t;
    endfunction

    localparam sbox_tab_t SBOX     = make_sbox(1'b0);
    localparam sbox_tab_t INV_SBOX = make_sbox(1'b1);

endpackage

/* rtl/aes_key_unit.sv */
// aes_key_unit: round key store, one 128-bit round key expanded per cycle
// depends on aes_pkg
module aes_key_unit #(
    parameter int ROUNDS = aes_pkg::ROUND_COUNT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [127:0]           key,
    input  logic [$clog2(ROUNDS+1)-1:0] rd_idx,
    output logic [127:0]           rd_key,
    output logic                   busy
);
    import aes_pkg::*;
    localparam int IW = $clog2(ROUNDS + 1);

    logic [127:0] rk_reg [ROUNDS+1];
    logic [127:0] cur_reg;
    logic [7:0]   rcon_reg;
    logic [IW-1:0] cnt_reg;
    logic         busy_reg;
    logic [127:0] nxt;
    logic [31:0]  t;

    always_comb begin
        t = {SBOX[cur_reg[23:16]] ^ rcon_reg, SBOX[cur_reg[15:8]],
             SBOX[cur_reg[7:0]], SBOX[cur_reg[31:24]]};
        nxt[127:96] = cur_reg[127:96] ^ t;
        nxt[95:64]  = cur_reg[95:64] ^ nxt[127:96];
        nxt[63:32]  = cur_reg[63:32] ^ nxt[95:64];
        nxt[31:0]   = cur_reg[31:0] ^ nxt[63:32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            cnt_reg  <= IW'(1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == IW'(ROUNDS)) busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg   <= key;
            rk_reg[0] <= key;
            rcon_reg  <= RCON_INIT;
        end else if (busy_reg) begin
            cur_reg         <= nxt;
            rk_reg[cnt_reg] <= nxt;
            rcon_reg        <= xtime(rcon_reg);
        end
    end

    assign rd_key = rk_reg[rd_idx];
    assign busy   = busy_reg;
endmodule

/* rtl/aes_round_unit.sv */
// aes_round_unit: one shared aes round per cycle, forward or inverse
// depends on aes_pkg
module aes_round_unit (
    input  logic                    aclk,
    input  aes_pkg::round_ctl_t     ctl,
    input  logic [127:0]            din,
    input  logic [127:0]            rkey,
    output logic [127:0]            state
);
    import aes_pkg::*;

    logic [127:0] st_reg;
    logic [7:0] s [16];
    logic [7:0] sh [16];
    logic [7:0] sb [16];
    logic [7:0] mx [16];
    logic [7:0] mi [16];
    logic [7:0] ak [16];
    logic [127:0] fwd, inv;

    // byte i sits at bits 127-8i; column-major like the spec
    always_comb begin
        for (int i = 0; i < 16; i++) s[i] = st_reg[127-8*i -: 8];
        // forward: sub, shift, mix, add key
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                sh[r+4*c] = SBOX[s[r+4*((c+r)&3)]];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                mx[4*c+r] = gmul(sh[4*c+r], 4'd2) ^ gmul(sh[4*c+((r+1)&3)], 4'd3) ^
                            sh[4*c+((r+2)&3)] ^ sh[4*c+((r+3)&3)];
        for (int i = 0; i < 16; i++)
            fwd[127-8*i -: 8] = (ctl.final_round ? sh[i] : mx[i]) ^ rkey[127-8*i -: 8];
        // inverse: shift, sub, add key, mix
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                sb[r+4*c] = INV_SBOX[s[r+4*((c+3*r)&3)]];
        for (int i = 0; i < 16; i++) ak[i] = sb[i] ^ rkey[127-8*i -: 8];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                mi[4*c+r] = gmul(ak[4*c+r], 4'd14) ^ gmul(ak[4*c+((r+1)&3)], 4'd11) ^
                            gmul(ak[4*c+((r+2)&3)], 4'd13) ^ gmul(ak[4*c+((r+3)&3)], 4'd9);
        for (int i = 0; i < 16; i++)
            inv[127-8*i -: 8] = ctl.final_round ? ak[i] : mi[i];
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) st_reg <= din ^ rkey;
        else if (!ctl.first_round) st_reg <= ctl.decrypt ? inv : fwd;
    end

    assign state = st_reg;
endmodule

/* rtl/aes128_cbc_pkcs7_engine.sv */
// aes128_cbc_pkcs7_engine: top level, sequencer, cbc chaining and padding
// depends on aes_pkg, aes_key_unit, aes_round_unit
//
// usage: write mode, key and iv through the cfg channel while idle (index 0
// mode, 1/2 key high/low, 3/4 iv high/low). send 16-byte blocks on s_axis;
// tlast marks the final block of a message, tuser carries the tail byte count.
// one result comes out on m_axis per block: tdata holds the block, tuser holds
// valid_bytes and pad_error.
// at the first block of a message the key is expanded first, one round key
// per cycle. each block then passes through whitening, ten rounds in the
// single shared round unit and a step that registers the result, in that
// order. the next block can be taken only after the result is registered.
// a new block is taken once the result register is free or being drained in
// the same cycle; a stalled receiver holds the result and blocks new input.
// reset clears the message state so the next block starts a fresh message
// with the key and iv registers, both zero after reset.
module aes128_cbc_pkcs7_engine #(
    parameter int ROUNDS = aes_pkg::ROUND_COUNT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // block_high [63:0], block_low [127:64]
    input  logic         s_axis_tlast,   // last_block
    input  logic [3:0]   s_axis_tuser,   // tail_bytes
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // result_high [63:0], result_low [127:64]
    output logic [7:0]   m_axis_tuser,   // valid_bytes [4:0], pad_error [5], zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import aes_pkg::*;
    localparam int IW = $clog2(ROUNDS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEY  = 3'd1;
    localparam logic [2:0] ST_WHT  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]   st_reg;
    logic         mode_reg, dec_reg, start_reg, last_reg;
    logic [127:0] key_reg, iv_reg, chain_reg, blk_reg, in_reg;
    logic [IW-1:0] rnd_reg;
    logic         ov_reg;
    logic [127:0] od_reg;
    logic [5:0]   ou_reg;

    logic         key_load, key_busy;
    logic [IW-1:0] rk_idx;
    logic [127:0] rkey, rstate;
    round_ctl_t   ctl;
    logic [127:0] chain_use, pre, plain;
    logic [7:0]   pb [16];
    logic [7:0]   padv;
    logic [4:0]   valid_n;
    logic         err_n, ok;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (st_reg == ST_IDLE) && (!ov_reg || m_axis_tready);
    wire in_xfer = s_axis_tvalid && s_axis_tready;
    wire [127:0] in_be = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    assign key_load = in_xfer && start_reg;
    assign chain_use = start_reg ? iv_reg : chain_reg;

    // encrypt padding applied on entry
    always_comb begin
        padv = 8'd16 - {4'd0, s_axis_tuser};
        for (int i = 0; i < 16; i++)
            pre[127-8*i -: 8] = (!mode_reg && s_axis_tlast && i >= s_axis_tuser)
                                ? padv : in_be[127-8*i -: 8];
    end

    always_comb begin
        rk_idx = dec_reg ? IW'(ROUNDS) - rnd_reg : rnd_reg;
        ctl.start       = (st_reg == ST_WHT);
        ctl.decrypt     = dec_reg;
        ctl.final_round = (rnd_reg == IW'(ROUNDS));
        ctl.first_round = (st_reg != ST_RND);
    end

    aes_key_unit #(.ROUNDS(ROUNDS)) u_key (
        .aclk(aclk), .aresetn(aresetn), .load(key_load), .key(key_reg),
        .rd_idx(rk_idx), .rd_key(rkey), .busy(key_busy)
    );

    aes_round_unit u_round (
        .aclk(aclk), .ctl(ctl), .din(blk_reg), .rkey(rkey), .state(rstate)
    );

    // output select (cbc chain xor when decrypting) and padding check
    always_comb begin
        plain = dec_reg ? (rstate ^ chain_reg) : rstate;
        for (int i = 0; i < 16; i++) pb[i] = plain[127-8*i -: 8];
        ok = (pb[15] >= 8'd1) && (pb[15] <= 8'd16);
        for (int i = 0; i < 16; i++)
            if ((16 - i) <= pb[15] && pb[i] != pb[15]) ok = 1'b0;
        valid_n = 5'd16;
        err_n   = 1'b0;
        if (dec_reg && last_reg) begin
            valid_n = ok ? 5'd16 - pb[15][4:0] : 5'd0;
            err_n   = !ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            start_reg <= 1'b1;
            ov_reg    <= 1'b0;
            mode_reg  <= 1'b0;
            key_reg   <= '0;
            iv_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MODE:   mode_reg <= cfg_data[0];
                    REG_KEY_HI: key_reg[127:64] <= cfg_data;
                    REG_KEY_LO: key_reg[63:0]   <= cfg_data;
                    REG_IV_HI:  iv_reg[127:64]  <= cfg_data;
                    REG_IV_LO:  iv_reg[63:0]    <= cfg_data;
                    default: ;
                endcase
            end
            if (ov_reg && m_axis_tready) ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE: if (in_xfer) begin
                    st_reg    <= start_reg ? ST_KEY : ST_WHT;
                    start_reg <= 1'b0;
                end
                ST_KEY:  if (!key_busy) st_reg <= ST_WHT;
                ST_WHT:  st_reg <= ST_RND;
                ST_RND:  if (rnd_reg == IW'(ROUNDS)) st_reg <= ST_DONE;
                ST_DONE: begin
                    st_reg    <= ST_IDLE;
                    ov_reg    <= 1'b1;
                    start_reg <= last_reg;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            dec_reg   <= mode_reg;
            last_reg  <= s_axis_tlast;
            in_reg    <= in_be;
            blk_reg   <= mode_reg ? in_be : (pre ^ chain_use);
            chain_reg <= chain_use;
        end
        // round 0 selects the whitening key during ST_WHT
        if (in_xfer) rnd_reg <= '0;
        else if (st_reg == ST_WHT) rnd_reg <= IW'(1);
        else if (st_reg == ST_RND && rnd_reg != IW'(ROUNDS)) rnd_reg <= rnd_reg + 1'b1;
        if (st_reg == ST_DONE) begin
            od_reg    <= plain;
            ou_reg    <= {err_n, valid_n};
            chain_reg <= dec_reg ? in_reg : rstate;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {od_reg[63:0], od_reg[127:64]};
    assign m_axis_tuser  = {2'b00, ou_reg};

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> st_reg == ST_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    a_err_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[5]) |-> m_axis_tuser[4:0] == 5'd0)
        else $error("pad error with valid bytes");
endmodule
